>>> rtl/core/urt_pkg.sv
// shared types and constants for the user region table
package urt_pkg;

  localparam int ADDR_W    = 48;
  localparam int SIZE_W    = 49;
  localparam int WSTART_W  = 48;
  localparam int WEND_W    = 49;
  localparam int FLAG_W    = 12;
  localparam int END_W     = 50;
  localparam int CFG_W     = 49;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_END   = 1'd1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2
  } urt_action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_ALIGN   = 3'd2,
    ST_WINDOW  = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_FULL    = 3'd5,
    ST_MISS    = 3'd6
  } urt_status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHECK = 2'd1,
    S_WALK  = 2'd2,
    S_DONE  = 2'd3
  } urt_state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] region_size;
    logic [FLAG_W-1:0] access_flags;
  } urt_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [FLAG_W-1:0] found_flags;
  } urt_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } urt_cmd_t;

  typedef struct packed {
    logic pre_err;
    logic walk_end;
  } urt_sts_t;

endpackage

>>> rtl/core/urt_ram.sv
// generic single-port ram with registered read
module urt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/urt_ctrl.sv
// sequencer for the region table: accept, pre-check, slot walk, finish
module urt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          action_i,
  input  urt_pkg::urt_sts_t   sts_i,
  output urt_pkg::urt_cmd_t   cmd_o,
  output logic                busy
);
  import urt_pkg::*;

  urt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (action_i)
            ACT_ADD:    state_d = S_CHECK;
            ACT_LOOKUP: state_d = S_WALK;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        state_d = sts_i.pre_err ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_WALK: begin
        cmd_o.step = !sts_i.walk_end;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (state_q == S_IDLE))
    else $error("finish not followed by idle");

  a_add_checks_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && action_i == ACT_ADD) |=> (state_q == S_CHECK))
    else $error("add skipped the pre-check");

  a_walk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && sts_i.walk_end) |=> (state_q == S_DONE))
    else $error("walk did not finish at the last slot");

endmodule

>>> rtl/core/urt_dp.sv
// region table datapath: window registers, slot store, walk compare, result
module urt_dp #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_SHIFT  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urt_pkg::urt_in_t              item_i,
  input  urt_pkg::urt_cmd_t             cmd_i,
  output urt_pkg::urt_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [urt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [urt_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          done_o,
  output urt_pkg::urt_out_t             result_o
);
  import urt_pkg::*;

  localparam int IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW   = $clog2(MAX_REGIONS + 1);
  localparam int SPW  = ADDR_W - PAGE_SHIFT;
  localparam int EPW  = WEND_W - PAGE_SHIFT;
  localparam int NEPW = END_W - PAGE_SHIFT;
  localparam int RW   = SPW + EPW + FLAG_W;

  // window registers
  logic [WSTART_W-1:0] win_start_q;
  logic [WEND_W-1:0]   win_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= WSTART_W'(64'd4194304);
      win_end_q   <= WEND_W'(64'd140737488355328);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIN_START: win_start_q <= cfg_data_i[WSTART_W-1:0];
        REG_WIN_END:   win_end_q   <= cfg_data_i[WEND_W-1:0];
        default:       win_end_q   <= win_end_q;
      endcase
    end
  end

  // latched item
  urt_action_e       act_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SIZE_W-1:0] size_q;
  logic [FLAG_W-1:0] flags_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= urt_action_e'(item_i.action);
      addr_q  <= item_i.address;
      size_q  <= item_i.region_size;
      flags_q <= item_i.access_flags;
    end
  end

  // pre-checks for add
  logic [END_W-1:0] end_w;
  logic [SPW-1:0]   page_w;
  logic [NEPW-1:0]  nep_w;
  urt_status_e      pre_st;

  assign end_w  = END_W'(addr_q) + END_W'(size_q);
  assign page_w = addr_q[ADDR_W-1:PAGE_SHIFT];
  assign nep_w  = end_w[END_W-1:PAGE_SHIFT];

  always_comb begin
    pre_st = ST_OK;
    if (size_q == '0) begin
      pre_st = ST_ZERO;
    end else if ((addr_q[PAGE_SHIFT-1:0] != '0) || (size_q[PAGE_SHIFT-1:0] != '0)) begin
      pre_st = ST_ALIGN;
    end else if ((addr_q < win_start_q) || (end_w > END_W'(win_end_q))) begin
      pre_st = ST_WINDOW;
    end
  end

  // slot walk
  logic [CW-1:0]          cnt_q;
  logic                   s1_vld_q;
  logic [IW-1:0]          s1_idx_q;
  logic [MAX_REGIONS-1:0] valid_q;
  logic                   ovl_q, hit_q, free_q;
  logic [IW-1:0]          free_idx_q;
  logic [FLAG_W-1:0]      hit_flags_q;

  logic                   ram_we;
  logic [IW-1:0]          ram_addr;
  logic [RW-1:0]          ram_wdata, ram_rdata;
  logic [SPW-1:0]         sp_s;
  logic [EPW-1:0]         ep_s;
  logic [FLAG_W-1:0]      fl_s;
  logic                   slot_v, ovl_now, hit_now;

  assign sts_o.walk_end = (cnt_q == CW'(MAX_REGIONS));
  assign sts_o.pre_err  = (pre_st != ST_OK);

  assign {sp_s, ep_s, fl_s} = ram_rdata;
  assign slot_v  = s1_vld_q && valid_q[s1_idx_q];
  assign ovl_now = slot_v && (NEPW'(page_w) < NEPW'(ep_s)) && (nep_w > NEPW'(sp_s));
  assign hit_now = slot_v && (page_w >= sp_s) && (EPW'(page_w) < ep_s);

  // final status
  urt_status_e fin_st;
  logic        add_ok;

  always_comb begin
    fin_st = ST_OK;
    case (act_q)
      ACT_ADD: begin
        if (pre_st != ST_OK) begin
          fin_st = pre_st;
        end else if (ovl_q) begin
          fin_st = ST_OVERLAP;
        end else if (!free_q) begin
          fin_st = ST_FULL;
        end
      end
      ACT_LOOKUP: begin
        fin_st = hit_q ? ST_OK : ST_MISS;
      end
      default: begin
        fin_st = ST_OK;
      end
    endcase
  end

  assign add_ok    = cmd_i.finish && (act_q == ACT_ADD) && (fin_st == ST_OK);
  assign ram_we    = add_ok;
  assign ram_addr  = cmd_i.finish ? free_idx_q : cnt_q[IW-1:0];
  assign ram_wdata = {page_w, nep_w[EPW-1:0], flags_q};

  urt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_REGIONS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      s1_vld_q <= 1'b0;
      ovl_q    <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      valid_q  <= '0;
    end else begin
      s1_vld_q <= cmd_i.step;
      if (cmd_i.load) begin
        cnt_q  <= '0;
        ovl_q  <= 1'b0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.step) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (ovl_now) begin
          ovl_q <= 1'b1;
        end
        if (hit_now && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (s1_vld_q && !valid_q[s1_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.finish && (act_q == ACT_CLEAR)) begin
        valid_q <= '0;
      end else if (add_ok) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      s1_idx_q <= cnt_q[IW-1:0];
    end
    if (hit_now && !hit_q) begin
      hit_flags_q <= fl_s;
    end
    if (s1_vld_q && !valid_q[s1_idx_q] && !free_q) begin
      free_idx_q <= s1_idx_q;
    end
  end

  // result register
  logic     done_q;
  urt_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.status      <= fin_st;
      res_q.found_flags <= (act_q == ACT_LOOKUP && hit_q) ? hit_flags_q : '0;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_miss_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status != ST_OK) |-> (res_q.found_flags == '0))
    else $error("flags reported without a hit");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && act_q == ACT_CLEAR) |=> (valid_q == '0))
    else $error("clear left a slot valid");

endmodule

>>> rtl/core/user_region_table.sv
// top level of the user region table: sequencer plus datapath
//
// channel  | signals                                  | notes
// ---------+------------------------------------------+-------------------------------
// item in  | start, busy, item_i                      | taken when start & !busy
// result   | done_o, result_o                         | one-cycle strobe, no back-pressure
// config   | cfg_we_i, cfg_idx_i, cfg_data_i          | write-only, taken when cfg_we_i
//
// add runs the pre-check, then the slot walk, then the finish step (a pre-check
// refusal skips the walk), lookup runs the walk and the finish step, clear and the
// unused action code go straight to finish; the walk reads one slot a cycle through
// the single port of the slot ram, and no new item is taken until the sequencer is idle
// done_o rises the cycle after the finish step, while busy is already low
// reset clears the slot valid bits and loads the default window at once
// results cannot be held off: done_o flags each result for one cycle, and result_o holds it until the next finish
module user_region_table #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_SHIFT  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  urt_pkg::urt_in_t              item_i,
  // result channel
  output logic                          done_o,
  output urt_pkg::urt_out_t             result_o,
  // window registers
  input  logic                          cfg_we_i,
  input  logic [urt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [urt_pkg::CFG_W-1:0]     cfg_data_i
);
  import urt_pkg::*;

  // command and status between sequencer and datapath
  urt_cmd_t cmd;
  urt_sts_t sts;

  // sequencer: idle, pre-check for add, slot walk, finish
  urt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (item_i.action),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // datapath: window regs, slot ram, compare stage and result register
  urt_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
